[rtl/core/mbfs_pkg.sv]
`default_nettype none

package mbfs_pkg;

    localparam int FIELD_W   = 28;
    localparam int QUO_W     = 24;
    localparam int DIV_W     = 35;
    localparam int STEP_W    = 5;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam logic [FIELD_W-1:0] FIELD_MAX   = '1;
    localparam logic [STEP_W-1:0]  STEPS_BALL  = 5'd24;
    localparam logic [STEP_W-1:0]  STEPS_RAMP  = 5'd8;

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_ADVANCE = 2'd1;
    localparam logic [1:0] OP_SHADE   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCR_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCR_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BALL_COUNT = 3'd4;

    typedef struct packed {
        logic load_we;
        logic adv_wr;
        logic shade_start;
        logic sub;
        logic mul;
        logic div_ball;
        logic acc;
        logic div_ramp;
        logic out_load;
    } t_cmd;

endpackage

`default_nettype wire

[rtl/core/mbfs_ram.sv]
`default_nettype none

module mbfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[rtl/core/mbfs_div.sv]
`default_nettype none

module mbfs_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [mbfs_pkg::STEP_W-1:0] i_steps,
    input  wire logic [mbfs_pkg::DIV_W-1:0]  i_num,
    input  wire logic [mbfs_pkg::DIV_W-1:0]  i_den,
    output logic                            o_done,
    output logic      [mbfs_pkg::QUO_W-1:0]  o_quo
);

    import mbfs_pkg::*;

    logic [DIV_W-1:0]  r_rem, r_num, r_den;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy;
    logic [DIV_W:0]    trial;
    logic              ge;

    assign trial = {r_rem, r_num[DIV_W-1]};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
                r_den  <= i_den;
                r_rem  <= i_num >> i_steps;
                r_num  <= i_num << (6'(DIV_W) - 6'(i_steps));
                o_quo  <= '0;
            end else if (r_busy) begin
                r_rem <= ge ? DIV_W'(trial - {1'b0, r_den}) : DIV_W'(trial);
                r_num <= r_num << 1;
                o_quo <= {o_quo[QUO_W-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

[rtl/core/mbfs_datapath.sv]
`default_nettype none

module mbfs_datapath #(
    parameter int MAX_BALLS  = 16,
    parameter int COORD_BITS = 12,
    parameter int AW         = 4
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire mbfs_pkg::t_cmd        i_cmd,
    input  wire logic [AW-1:0]         i_addr,
    input  wire logic [15:0]           i_threshold,
    input  wire logic                  i_color_mode,
    input  wire logic [12:0]           i_screen_width,
    input  wire logic [12:0]           i_screen_height,
    input  wire logic [3:0]            i_ball_index,
    input  wire logic [11:0]           i_ball_x,
    input  wire logic [11:0]           i_ball_y,
    input  wire logic signed [3:0]     i_ball_vx,
    input  wire logic signed [3:0]     i_ball_vy,
    input  wire logic [7:0]            i_ball_radius,
    input  wire logic [11:0]           i_sample_x,
    input  wire logic [11:0]           i_sample_y,
    output logic                       o_div_done,
    output logic [7:0]                 o_red,
    output logic [7:0]                 o_green,
    output logic [7:0]                 o_blue,
    output logic [27:0]                o_field_sum
);

    import mbfs_pkg::*;

    localparam int CB = COORD_BITS;
    localparam int WW = 2 * CB + 16;

    logic [WW-1:0]  wdata, rdata, adv_word;
    logic           we;
    logic [AW-1:0]  waddr;
    logic [6:0]     idx7;
    logic [15:0]    bx16, by16, sx16, sy16;

    logic [CB-1:0]        rd_px, rd_py;
    logic signed [3:0]    rd_vx, rd_vy;
    logic [7:0]           rd_r;

    logic [CB-1:0]        r_sx, r_sy;
    logic signed [CB:0]   r_dx, r_dy;
    logic [7:0]           r_rad;
    logic [2*CB-1:0]      r_dx2, r_dy2;
    logic [15:0]          r_rr;
    logic [FIELD_W-1:0]   r_acc;
    logic signed [2*CB+1:0] sq_x, sq_y;
    logic [2*CB:0]        d2;
    logic [FIELD_W:0]     acc_sum;

    logic [CB:0]          lim_x, lim_y;

    logic                 div_start;
    logic [STEP_W-1:0]    div_steps;
    logic [DIV_W-1:0]     div_num, div_den;
    logic [QUO_W-1:0]     div_quo;

    logic [17:0]          ramp_lim;
    logic [7:0]           t;
    logic [7:0]           t4, r_c, g_c, b_c;

    function automatic logic [CB:0] screen_lim(input logic [12:0] s);
        logic [17:0] s18;
        logic [17:0] cap;
        begin
            s18 = 18'(s);
            cap = 18'(1) << CB;
            if (s == 13'd0) begin
                screen_lim = (CB+1)'(1);
            end else if (s18 > cap) begin
                screen_lim = (CB+1)'(cap);
            end else begin
                screen_lim = (CB+1)'(s18);
            end
        end
    endfunction

    function automatic logic signed [3:0] flip_vel(input logic signed [3:0] v);
        begin
            flip_vel = (v == -4'sd8) ? 4'sd7 : -v;
        end
    endfunction

    function automatic logic [CB+3:0] bounce(input logic [CB-1:0] pos,
                                             input logic signed [3:0] vel,
                                             input logic [CB:0] lim);
        logic signed [CB+1:0] p;
        logic signed [3:0]    v;
        begin
            v = vel;
            p = $signed({2'b00, pos}) + (CB+2)'(vel);
            if (p < 0) begin
                p = '0;
                v = flip_vel(v);
            end
            if (p >= $signed({1'b0, lim})) begin
                p = $signed({1'b0, lim}) - 1;
                v = flip_vel(v);
            end
            bounce = {p[CB-1:0], v};
        end
    endfunction

    assign idx7 = 7'(i_ball_index);
    assign bx16 = 16'(i_ball_x);
    assign by16 = 16'(i_ball_y);
    assign sx16 = 16'(i_sample_x);
    assign sy16 = 16'(i_sample_y);

    assign rd_px = rdata[WW-1 -: CB];
    assign rd_py = rdata[WW-CB-1 -: CB];
    assign rd_vx = rdata[15:12];
    assign rd_vy = rdata[11:8];
    assign rd_r  = rdata[7:0];

    assign lim_x = screen_lim(i_screen_width);
    assign lim_y = screen_lim(i_screen_height);

    always_comb begin
        logic [CB+3:0] bx, by;
        bx = bounce(rd_px, rd_vx, lim_x);
        by = bounce(rd_py, rd_vy, lim_y);
        adv_word = {bx[CB+3:4], by[CB+3:4], bx[3:0], by[3:0], rd_r};
    end

    assign we    = i_cmd.load_we | i_cmd.adv_wr;
    assign waddr = i_cmd.load_we ? idx7[AW-1:0] : i_addr;
    assign wdata = i_cmd.load_we ?
                   {bx16[CB-1:0], by16[CB-1:0], i_ball_vx, i_ball_vy, i_ball_radius} :
                   adv_word;

    mbfs_ram #(.WIDTH(WW), .DEPTH(MAX_BALLS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (i_addr),
        .o_rdata (rdata)
    );

    assign sq_x    = r_dx * r_dx;
    assign sq_y    = r_dy * r_dy;
    assign d2      = (2*CB+1)'(r_dx2) + (2*CB+1)'(r_dy2) + (2*CB+1)'(1);
    assign acc_sum = {1'b0, r_acc} + (FIELD_W+1)'(div_quo);

    assign div_start = i_cmd.div_ball | i_cmd.div_ramp;
    assign div_steps = i_cmd.div_ball ? STEPS_BALL : STEPS_RAMP;
    assign div_num   = i_cmd.div_ball ? DIV_W'({r_rr, 8'd0}) : DIV_W'({r_acc, 7'd0});
    assign div_den   = i_cmd.div_ball ? DIV_W'(d2) : DIV_W'({1'b0, i_threshold} + 17'd1);

    mbfs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_steps (div_steps),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (o_div_done),
        .o_quo   (div_quo)
    );

    assign ramp_lim = ({2'b00, i_threshold} + 18'd1) << 1;
    assign t  = ((FIELD_W+1)'(r_acc) >= (FIELD_W+1)'(ramp_lim)) ? 8'd255 : div_quo[7:0];
    assign t4 = {t[5:0], 2'b00};

    always_comb begin
        r_c = 8'd0;
        g_c = 8'd0;
        b_c = 8'd0;
        if (i_color_mode) begin
            if (r_acc >= FIELD_W'(i_threshold >> 2)) begin
                case (t[7:6])
                    2'd0: begin
                        g_c = t4;
                        b_c = 8'd255;
                    end
                    2'd1: begin
                        g_c = 8'd255;
                        b_c = ~t4;
                    end
                    2'd2: begin
                        r_c = t4;
                        g_c = 8'd255;
                    end
                    default: begin
                        r_c = 8'd255;
                        g_c = ~t4;
                        b_c = t4;
                    end
                endcase
            end
        end else if (r_acc >= FIELD_W'(i_threshold)) begin
            r_c = 8'd255;
            g_c = 8'd255;
            b_c = 8'd255;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.shade_start) begin
            r_sx  <= sx16[CB-1:0];
            r_sy  <= sy16[CB-1:0];
            r_acc <= '0;
        end
        if (i_cmd.sub) begin
            r_dx  <= $signed({1'b0, r_sx}) - $signed({1'b0, rd_px});
            r_dy  <= $signed({1'b0, r_sy}) - $signed({1'b0, rd_py});
            r_rad <= rd_r;
        end
        if (i_cmd.mul) begin
            r_dx2 <= sq_x[2*CB-1:0];
            r_dy2 <= sq_y[2*CB-1:0];
            r_rr  <= r_rad * r_rad;
        end
        if (i_cmd.acc) begin
            r_acc <= acc_sum[FIELD_W] ? FIELD_MAX : acc_sum[FIELD_W-1:0];
        end
        if (i_cmd.out_load) begin
            o_red       <= r_c;
            o_green     <= g_c;
            o_blue      <= b_c;
            o_field_sum <= r_acc;
        end
    end

endmodule

`default_nettype wire

[rtl/core/mbfs_ctrl.sv]
`default_nettype none

module mbfs_ctrl #(
    parameter int MAX_BALLS = 16,
    parameter int AW        = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire logic [1:0]    i_operation,
    input  wire logic [3:0]    i_ball_index,
    input  wire logic [4:0]    i_ball_count,
    input  wire logic          i_div_done,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output mbfs_pkg::t_cmd     o_cmd,
    output logic [AW-1:0]      o_addr
);

    import mbfs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_ADV_RD, S_ADV_WR, S_SH_RD, S_SH_SUB, S_SH_MUL,
        S_SH_GO, S_SH_DIV, S_RAMP_GO, S_RAMP_DIV, S_DONE
    } t_state;

    t_state     r_state, n_state;
    logic [6:0] r_idx, n_idx;
    logic [6:0] n_balls;
    logic       last, accept, out_free;

    assign n_balls    = (7'(i_ball_count) > 7'(MAX_BALLS)) ? 7'(MAX_BALLS) : 7'(i_ball_count);
    assign last       = (r_idx + 7'd1) == n_balls;
    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !o_out_valid || i_out_ready;
    assign o_addr     = r_idx[AW-1:0];

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_idx = '0;
                    unique case (i_operation)
                        OP_LOAD: begin
                            o_cmd.load_we = 7'(i_ball_index) < 7'(MAX_BALLS);
                        end
                        OP_ADVANCE: begin
                            if (n_balls != 7'd0) begin
                                n_state = S_ADV_RD;
                            end
                        end
                        OP_SHADE: begin
                            o_cmd.shade_start = 1'b1;
                            n_state = (n_balls != 7'd0) ? S_SH_RD : S_RAMP_GO;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_ADV_RD: n_state = S_ADV_WR;
            S_ADV_WR: begin
                o_cmd.adv_wr = 1'b1;
                if (last) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx   = r_idx + 7'd1;
                    n_state = S_ADV_RD;
                end
            end
            S_SH_RD: n_state = S_SH_SUB;
            S_SH_SUB: begin
                o_cmd.sub = 1'b1;
                n_state   = S_SH_MUL;
            end
            S_SH_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SH_GO;
            end
            S_SH_GO: begin
                o_cmd.div_ball = 1'b1;
                n_state        = S_SH_DIV;
            end
            S_SH_DIV: begin
                if (i_div_done) begin
                    o_cmd.acc = 1'b1;
                    if (last) begin
                        n_state = S_RAMP_GO;
                    end else begin
                        n_idx   = r_idx + 7'd1;
                        n_state = S_SH_RD;
                    end
                end
            end
            S_RAMP_GO: begin
                o_cmd.div_ramp = 1'b1;
                n_state        = S_RAMP_DIV;
            end
            S_RAMP_DIV: begin
                if (i_div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (o_cmd.out_load) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.adv_wr || o_cmd.sub) |-> (r_idx < n_balls))
        else $error("ball index beyond active count");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!o_out_valid || i_out_ready))
        else $error("result overwrote a pending request");

    a_done_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_div_done |-> (r_state == S_SH_DIV || r_state == S_RAMP_DIV))
        else $error("divider finished with no division pending");
`endif

endmodule

`default_nettype wire

[rtl/core/metaball_field_shader_top.sv]
// Metaball field shader.
// Input channel (i_in_valid / o_in_ready) takes one request: load a ball slot,
// advance all active balls one frame, or shade one sample point.
// Output channel (o_out_valid / i_out_ready) returns one color and field sum
// for each shade request; load and advance requests return nothing.
// A load writes the ball slot as the request is accepted. An advance reads each
// active ball from the RAM and writes it back moved, one ball after another. A
// shade reads, subtracts, squares and divides each active ball on the shared
// 24-step radix-2 divider, then does the color ramp division and result load.
// The result register frees the core, so the next request is taken while a
// finished result still waits; a second shade result then waits in the core
// until the receiver takes the first one.
// Configuration writes (i_cfg_we, i_cfg_addr, i_cfg_wdata) take effect at once.
// The user must make them only while the block is idle; nothing enforces it.
// Reset restores the register defaults and idles the core; the ball table is
// not cleared and must be loaded before use.
`default_nettype none

module metaball_field_shader_top #(
    parameter int MAX_BALLS  = 16,
    parameter int COORD_BITS = 12
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [mbfs_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  wire logic [mbfs_pkg::CFG_DAT_W-1:0]     i_cfg_wdata,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic [1:0]                         i_operation,
    input  wire logic [3:0]                         i_ball_index,
    input  wire logic [11:0]                        i_ball_x,
    input  wire logic [11:0]                        i_ball_y,
    input  wire logic signed [3:0]                  i_ball_vx,
    input  wire logic signed [3:0]                  i_ball_vy,
    input  wire logic [7:0]                         i_ball_radius,
    input  wire logic [11:0]                        i_sample_x,
    input  wire logic [11:0]                        i_sample_y,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic [7:0]                              o_red,
    output logic [7:0]                              o_green,
    output logic [7:0]                              o_blue,
    output logic [27:0]                             o_field_sum
);

    import mbfs_pkg::*;

    localparam int AW = (MAX_BALLS > 1) ? $clog2(MAX_BALLS) : 1;

    logic [15:0]   r_threshold;
    logic          r_color_mode;
    logic [12:0]   r_screen_width, r_screen_height;
    logic [4:0]    r_ball_count;
    t_cmd          cmd;
    logic [AW-1:0] addr;
    logic          div_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold     <= 16'd220;
            r_color_mode    <= 1'b0;
            r_screen_width  <= 13'd640;
            r_screen_height <= 13'd480;
            r_ball_count    <= 5'd10;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_THRESHOLD:  r_threshold     <= i_cfg_wdata;
                CFG_COLOR_MODE: r_color_mode    <= i_cfg_wdata[0];
                CFG_SCR_WIDTH:  r_screen_width  <= i_cfg_wdata[12:0];
                CFG_SCR_HEIGHT: r_screen_height <= i_cfg_wdata[12:0];
                CFG_BALL_COUNT: r_ball_count    <= i_cfg_wdata[4:0];
                default: begin
                end
            endcase
        end
    end

    mbfs_ctrl #(.MAX_BALLS(MAX_BALLS), .AW(AW)) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_operation  (i_operation),
        .i_ball_index (i_ball_index),
        .i_ball_count (r_ball_count),
        .i_div_done   (div_done),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_cmd        (cmd),
        .o_addr       (addr)
    );

    mbfs_datapath #(.MAX_BALLS(MAX_BALLS), .COORD_BITS(COORD_BITS), .AW(AW)) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_addr          (addr),
        .i_threshold     (r_threshold),
        .i_color_mode    (r_color_mode),
        .i_screen_width  (r_screen_width),
        .i_screen_height (r_screen_height),
        .i_ball_index    (i_ball_index),
        .i_ball_x        (i_ball_x),
        .i_ball_y        (i_ball_y),
        .i_ball_vx       (i_ball_vx),
        .i_ball_vy       (i_ball_vy),
        .i_ball_radius   (i_ball_radius),
        .i_sample_x      (i_sample_x),
        .i_sample_y      (i_sample_y),
        .o_div_done      (div_done),
        .o_red           (o_red),
        .o_green         (o_green),
        .o_blue          (o_blue),
        .o_field_sum     (o_field_sum)
    );

endmodule

`default_nettype wire
